FILE: sv/tbr_pkg.sv
// ---------------------------------------------------------------------------
// tbr_pkg
// shared types and constants for the triangle bounding box rasterizer
// ---------------------------------------------------------------------------
package tbr_pkg;

    localparam int COORD_BITS = 12;
    localparam int MAX_DIM    = 1024;
    localparam int DIM_BITS   = 10;
    localparam int REG_BITS   = 11;
    localparam int AREA_BITS  = 27;
    localparam int IDX_BITS   = 20;
    localparam int COLOR_BITS = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS:0]   t_diff;
    typedef logic signed [AREA_BITS-1:0]  t_area;

    // one queued command from front to back
    typedef struct packed {
        logic                  cmd;
        logic                  busy;
        t_coord                x0;
        t_coord                y0;
        t_diff                 ax;
        t_diff                 ay;
        t_diff                 bx;
        t_diff                 by;
        t_area                 area;
        logic [DIM_BITS-1:0]   left;
        logic [DIM_BITS-1:0]   right;
        logic [DIM_BITS-1:0]   top;
        logic [DIM_BITS-1:0]   bottom;
        logic [COLOR_BITS-1:0] color;
    } t_cmd;

    function automatic logic [REG_BITS-1:0] sat_dim(input logic [REG_BITS-1:0] r);
        if (r > REG_BITS'(MAX_DIM)) begin
            return REG_BITS'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

FILE: sv/triangle_bbox_rasterizer_unit.sv
// ---------------------------------------------------------------------------
// triangle_bbox_rasterizer_unit
// Loads a triangle (cmd 0), then each step (cmd 1) returns the next pixel of
// its screen-clipped bounding box in row order with a strict inside flag.
// One item per clock while i_ready does not stall the output; a step result
// passes the front register that takes the transaction, the queue write
// and the output register, in that order. Loads return nothing. Each
// coverage test uses four 13x13 multipliers in the back stage.
// ---------------------------------------------------------------------------
module triangle_bbox_rasterizer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic signed [11:0]            i_vertex0_x,
    input  logic signed [11:0]            i_vertex0_y,
    input  logic signed [11:0]            i_vertex1_x,
    input  logic signed [11:0]            i_vertex1_y,
    input  logic signed [11:0]            i_vertex2_x,
    input  logic signed [11:0]            i_vertex2_y,
    input  logic [31:0]                   i_fill_rgba,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [10:0]                   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [9:0]                    o_pixel_x,
    output logic [9:0]                    o_pixel_y,
    output logic [19:0]                   o_fb_index,
    output logic                          o_covered,
    output logic [31:0]                   o_pixel_color,
    output logic                          o_last,
    output logic                          o_idle
);
    import tbr_pkg::*;

    logic [REG_BITS-1:0] r_width, r_height;
    logic                f_valid, f_ready, q_valid, q_ready;
    t_cmd                f_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= REG_BITS'(640);
            r_height <= REG_BITS'(480);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
        end
    end

    tbr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_cmd, .i_x0(i_vertex0_x), .i_y0(i_vertex0_y),
        .i_x1(i_vertex1_x), .i_y1(i_vertex1_y),
        .i_x2(i_vertex2_x), .i_y2(i_vertex2_y), .i_color(i_fill_rgba),
        .i_width(r_width), .i_height(r_height),
        .o_valid(f_valid), .i_ready(f_ready), .o_cmd(f_cmd)
    );

    tbr_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_cmd)
    );

    tbr_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .i_width(r_width), .o_valid, .i_ready, .o_pixel_x, .o_pixel_y,
        .o_fb_index, .o_covered, .o_pixel_color, .o_last, .o_idle
    );

`ifndef SYNTHESIS
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_idle |-> !o_covered && !o_last && o_pixel_color == '0)
        else $error("idle result carries data");
    a_cov_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_idle |-> o_pixel_x <= u_back.r_tri.right)
        else $error("pixel outside box");
`endif

endmodule

FILE: sv/tbr_front.sv
// ---------------------------------------------------------------------------
// tbr_front
// accepts commands, computes doubled signed area and clipped box of a loaded triangle
// ---------------------------------------------------------------------------
module tbr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  tbr_pkg::t_coord              i_x0,
    input  tbr_pkg::t_coord              i_y0,
    input  tbr_pkg::t_coord              i_x1,
    input  tbr_pkg::t_coord              i_y1,
    input  tbr_pkg::t_coord              i_x2,
    input  tbr_pkg::t_coord              i_y2,
    input  logic [31:0]                  i_color,
    input  logic [tbr_pkg::REG_BITS-1:0] i_width,
    input  logic [tbr_pkg::REG_BITS-1:0] i_height,
    output logic                         o_valid,
    input  logic                         i_ready,
    output tbr_pkg::t_cmd                o_cmd
);
    import tbr_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    t_diff ax, ay, bx, by;
    t_area p0, p1;
    t_coord lo_x, hi_x, lo_y, hi_y;
    logic signed [COORD_BITS:0] wl, hl, clx, chx, cly, chy;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        ax = t_diff'(i_x1) - t_diff'(i_x0);
        ay = t_diff'(i_y1) - t_diff'(i_y0);
        bx = t_diff'(i_x2) - t_diff'(i_x0);
        by = t_diff'(i_y2) - t_diff'(i_y0);
        p0 = t_area'(ax) * t_area'(by);
        p1 = t_area'(bx) * t_area'(ay);
        lo_x = (i_x0 < i_x1) ? i_x0 : i_x1;
        lo_x = (lo_x < i_x2) ? lo_x : i_x2;
        hi_x = (i_x0 > i_x1) ? i_x0 : i_x1;
        hi_x = (hi_x > i_x2) ? hi_x : i_x2;
        lo_y = (i_y0 < i_y1) ? i_y0 : i_y1;
        lo_y = (lo_y < i_y2) ? lo_y : i_y2;
        hi_y = (i_y0 > i_y1) ? i_y0 : i_y1;
        hi_y = (hi_y > i_y2) ? hi_y : i_y2;
        wl  = $signed({2'b00, sat_dim(i_width)}) - 13'sd1;
        hl  = $signed({2'b00, sat_dim(i_height)}) - 13'sd1;
        clx = (lo_x < 0) ? '0 : (COORD_BITS+1)'(lo_x);
        cly = (lo_y < 0) ? '0 : (COORD_BITS+1)'(lo_y);
        chx = ((COORD_BITS+1)'(hi_x) > wl) ? wl : (COORD_BITS+1)'(hi_x);
        chy = ((COORD_BITS+1)'(hi_y) > hl) ? hl : (COORD_BITS+1)'(hi_y);
        n_cmd        = '0;
        n_cmd.cmd    = i_cmd;
        n_cmd.busy   = !(clx > chx || cly > chy);
        n_cmd.x0     = i_x0;
        n_cmd.y0     = i_y0;
        n_cmd.ax     = ax;
        n_cmd.ay     = ay;
        n_cmd.bx     = bx;
        n_cmd.by     = by;
        n_cmd.area   = p0 - p1;
        n_cmd.left   = DIM_BITS'(clx);
        n_cmd.right  = DIM_BITS'(chx);
        n_cmd.top    = DIM_BITS'(cly);
        n_cmd.bottom = DIM_BITS'(chy);
        n_cmd.color  = i_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: sv/tbr_fifo.sv
// ---------------------------------------------------------------------------
// tbr_fifo
// two entry command queue between front and back
// ---------------------------------------------------------------------------
module tbr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tbr_pkg::t_cmd i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output tbr_pkg::t_cmd o_data
);
    import tbr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: sv/tbr_back.sv
// ---------------------------------------------------------------------------
// tbr_back
// holds the active triangle, walks the box and tests coverage per pixel
// ---------------------------------------------------------------------------
module tbr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  tbr_pkg::t_cmd                i_cmd,
    input  logic [tbr_pkg::REG_BITS-1:0] i_width,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [9:0]                   o_pixel_x,
    output logic [9:0]                   o_pixel_y,
    output logic [19:0]                  o_fb_index,
    output logic                         o_covered,
    output logic [31:0]                  o_pixel_color,
    output logic                         o_last,
    output logic                         o_idle
);
    import tbr_pkg::*;

    t_cmd                r_tri;
    logic                r_busy;
    logic [DIM_BITS-1:0] r_col, r_row;
    logic                r_valid;
    logic [9:0]          r_px, r_py;
    logic [19:0]         r_fb;
    logic                r_cov, r_last, r_idle;
    logic [31:0]         r_color;
    logic                take, step, fin;
    t_diff               cx, cy;
    t_area               u1, u2, u0;
    logic                cov;
    logic [IDX_BITS-1:0] fb;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign step    = take && i_cmd.cmd == CMD_STEP;
    assign fin     = r_col == r_tri.right && r_row == r_tri.bottom;

    always_comb begin
        cx = t_diff'(r_tri.x0) - t_diff'({1'b0, r_col});
        cy = t_diff'(r_tri.y0) - t_diff'({1'b0, r_row});
        u1 = t_area'(r_tri.bx) * t_area'(cy) - t_area'(cx) * t_area'(r_tri.by);
        u2 = t_area'(cx) * t_area'(r_tri.ay) - t_area'(r_tri.ax) * t_area'(cy);
        u0 = r_tri.area - u1 - u2;
        if (r_tri.area > 0) begin
            cov = u1 > 0 && u2 > 0 && u0 > 0;
        end else if (r_tri.area < 0) begin
            cov = u1 < 0 && u2 < 0 && u0 < 0;
        end else begin
            cov = 1'b0;
        end
        fb = IDX_BITS'(r_row) * IDX_BITS'(sat_dim(i_width)) + IDX_BITS'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= step;
            end
            if (take && i_cmd.cmd == CMD_LOAD) begin
                r_busy <= i_cmd.busy;
            end else if (step && r_busy && fin) begin
                r_busy <= 1'b0;
            end
        end
        if (take && i_cmd.cmd == CMD_LOAD) begin
            r_tri <= i_cmd;
            r_col <= i_cmd.left;
            r_row <= i_cmd.top;
        end else if (step && r_busy && !fin) begin
            if (r_col == r_tri.right) begin
                r_col <= r_tri.left;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (step) begin
            r_px    <= r_busy ? r_col : '0;
            r_py    <= r_busy ? r_row : '0;
            r_fb    <= r_busy ? fb : '0;
            r_cov   <= r_busy && cov;
            r_color <= r_busy ? r_tri.color : '0;
            r_last  <= r_busy && fin;
            r_idle  <= !r_busy;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_fb_index    = r_fb;
    assign o_covered     = r_cov;
    assign o_pixel_color = r_color;
    assign o_last        = r_last;
    assign o_idle        = r_idle;

endmodule
